[hw/rtl/div_tima_timer_step_core_defines.svh]
// Assertion macros for the divider/timer step core checker.
// Depends on a clk and an arst_n signal in the scope of use.
`ifndef DIV_TIMA_TIMER_STEP_CORE_DEFINES_SVH
`define DIV_TIMA_TIMER_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DTTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define DTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dtts_pkg.sv]
// Shared types and constants for the divider/timer step core.
// No dependencies.
package dtts_pkg;

	localparam int unsigned CYCLES_W  = 6;
	localparam int unsigned CLOCKS_W  = 8;
	localparam int unsigned DIV_W     = 8;
	localparam int unsigned TIMA_W    = 8;
	localparam int unsigned TRES_W    = 11;
	localparam int unsigned FRAME_W   = 15;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 8;

	// Timer rate select codes
	typedef enum logic [1:0] {
		SEL_1024 = 2'd0,
		SEL_16   = 2'd1,
		SEL_64   = 2'd2,
		SEL_256  = 2'd3
	} clk_sel_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMER_ENABLE = 2'd0,
		REG_CLOCK_SELECT = 2'd1,
		REG_TIMER_MODULO = 2'd2,
		REG_DOUBLE_SPEED = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              timer_enable;
		clk_sel_t          clock_select;
		logic [TIMA_W-1:0] timer_modulo;
		logic              double_speed;
	} cfg_t;

	typedef struct packed {
		logic [DIV_W-1:0]   div_count;
		logic [DIV_W-1:0]   div_res;
		logic [TIMA_W-1:0]  tima_count;
		logic [TRES_W-1:0]  tima_res;
		logic               reload_pending;
		logic [FRAME_W-1:0] frame_clock;
	} state_t;

endpackage

[hw/rtl/div_tima_timer_step_core.sv]
// Divider/timer step core: an input beat passes the input register, then the result
// register, to become a result beat. Throughput one beat per cycle;
// in_ready falls only while a result is held and out_ready is low.
// Reset clears configuration, counter state and both valid flags.
// Depends on dtts_pkg and dtts_step.
module div_tima_timer_step_core import dtts_pkg::*; #(
	parameter int unsigned FRAME_LENGTH = 17556
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CYCLES_W-1:0]  elapsed_cycles,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIV_W-1:0]     divider_value,
	output logic [TIMA_W-1:0]    timer_value,
	output logic                 timer_interrupt,
	output logic [FRAME_W-1:0]   frame_position,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t                cfg_q;
	state_t              state_q;
	state_t              state_nxt;
	logic                irq_nxt;
	logic                irq_q;
	logic                valid_s1;
	logic [CYCLES_W-1:0] cycles_s1;
	logic                valid_s2;
	logic                advance;

	// Move the held item on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIMER_ENABLE: cfg_q.timer_enable <= cfg_data[0];
				REG_CLOCK_SELECT: cfg_q.clock_select <= clk_sel_t'(cfg_data[1:0]);
				REG_TIMER_MODULO: cfg_q.timer_modulo <= cfg_data[TIMA_W-1:0];
				REG_DOUBLE_SPEED: cfg_q.double_speed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cycles_s1 <= elapsed_cycles;
		end
	end

	dtts_step #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_step (
		.cur    (state_q),
		.cfg    (cfg_q),
		.cycles (cycles_s1),
		.nxt    (state_nxt),
		.irq    (irq_nxt)
	);

	// Commit the step: counter state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			irq_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				irq_q    <= irq_nxt;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign divider_value   = state_q.div_count;
	assign timer_value     = state_q.tima_count;
	assign timer_interrupt = irq_q;
	assign frame_position  = state_q.frame_clock;

endmodule

[hw/rtl/dtts_step.sv]
// Next-state logic for one step of the divider/timer core.
// Depends on dtts_pkg.
module dtts_step import dtts_pkg::*; #(
	parameter int unsigned FRAME_LENGTH = 17556
) (
	input  state_t              cur,
	input  cfg_t                cfg,
	input  logic [CYCLES_W-1:0] cycles,
	output state_t              nxt,
	output logic                irq
);

	logic [CLOCKS_W-1:0]  clocks;
	logic [DIV_W:0]       div_sum;
	logic [TRES_W:0]      acc;
	logic [TIMA_W-1:0]    ticks;
	logic [TRES_W-1:0]    tres_next;
	logic [TIMA_W:0]      tsum;
	logic [CLOCKS_W-1:0]  clk_mod [1 << CLOCKS_W];
	logic [FRAME_W:0]     fsum;

	// Clocks folded into the frame length, worked out at elaboration
	for (genvar i = 0; i < (1 << CLOCKS_W); i++) begin : g_mod
		assign clk_mod[i] = CLOCKS_W'(i % FRAME_LENGTH);
	end

	// Scale machine cycles to clocks
	assign clocks = cfg.double_speed ? {1'b0, cycles, 1'b0} : {cycles, 2'b00};

	// Divider and frame position
	assign div_sum = {1'b0, cur.div_res} + {1'b0, clocks};
	assign fsum    = {1'b0, cur.frame_clock} + (FRAME_W + 1)'(clk_mod[clocks]);

	// Timer prescale: ticks and kept residue at the selected rate
	assign acc = {1'b0, cur.tima_res} + (TRES_W + 1)'(clocks);

	always_comb begin
		case (cfg.clock_select)
			SEL_1024: begin
				ticks     = TIMA_W'(acc[TRES_W:10]);
				tres_next = TRES_W'(acc[9:0]);
			end
			SEL_16: begin
				ticks     = acc[TIMA_W+3:4];
				tres_next = TRES_W'(acc[3:0]);
			end
			SEL_64: begin
				ticks     = TIMA_W'(acc[TRES_W:6]);
				tres_next = TRES_W'(acc[5:0]);
			end
			default: begin
				ticks     = TIMA_W'(acc[TRES_W:8]);
				tres_next = TRES_W'(acc[7:0]);
			end
		endcase
	end

	assign tsum = {1'b0, cur.tima_count} + {1'b0, ticks};

	// Assemble the next state
	always_comb begin
		nxt           = cur;
		irq           = 1'b0;
		nxt.div_count = cur.div_count + DIV_W'(div_sum[DIV_W]);
		nxt.div_res   = div_sum[DIV_W-1:0];
		if (fsum >= (FRAME_W + 1)'(FRAME_LENGTH)) begin
			nxt.frame_clock = FRAME_W'(fsum - (FRAME_W + 1)'(FRAME_LENGTH));
		end else begin
			nxt.frame_clock = fsum[FRAME_W-1:0];
		end
		if (cfg.timer_enable) begin
			nxt.tima_res = tres_next;
			if (cur.reload_pending) begin
				// Load the modulo plus this step's ticks
				nxt.tima_count     = cfg.timer_modulo + ticks;
				nxt.reload_pending = 1'b0;
			end else if (tsum[TIMA_W]) begin
				// Overflow: drop to zero, flag and arm the reload
				irq                = 1'b1;
				nxt.tima_count     = '0;
				nxt.reload_pending = 1'b1;
			end else begin
				nxt.tima_count = tsum[TIMA_W-1:0];
			end
		end
	end

endmodule

[hw/rtl/dtts_checker.sv]
// Port-level checks for the divider/timer step core, bound to the top level.
// Depends on dtts_pkg and div_tima_timer_step_core_defines.svh.
`include "div_tima_timer_step_core_defines.svh"

module dtts_checker import dtts_pkg::*; #(
	parameter int unsigned FRAME_LENGTH = 17556
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [DIV_W-1:0]    divider_value,
	input logic [TIMA_W-1:0]   timer_value,
	input logic                timer_interrupt,
	input logic [FRAME_W-1:0]  frame_position
);

	// A stalled result beat holds its payload
	`DTTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(divider_value) && $stable(timer_value) && $stable(timer_interrupt) && $stable(frame_position), "stalled result beat changed")

	// An empty result register never blocks the input
	`DTTS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result held")

	// Frame position stays inside the frame
	`DTTS_ASSERT_NOW(a_frame_range, out_valid, 32'(frame_position) < FRAME_LENGTH, "frame position out of range")

	// An overflow beat shows a cleared counter
	`DTTS_ASSERT_NOW(a_irq_zero, out_valid && timer_interrupt, timer_value == '0, "interrupt with nonzero counter")

endmodule

bind div_tima_timer_step_core dtts_checker #(.FRAME_LENGTH(FRAME_LENGTH)) u_dtts_checker (.*);

[tb/tb_top.sv]
// Self-checking bench for div_tima_timer_step_core: random-gap beat driver, stalling result
// monitor and a per-beat timer/divider predictor fed with the same register writes.
// Depends on dtts_pkg and the core RTL.
module tb_top;
	import dtts_pkg::*;

	localparam int unsigned FRAME_LEN   = 17556;
	localparam int unsigned RAND_BEATS  = 450;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SHOW_ERRS   = 10;

	typedef enum logic [1:0] {
		OP_BEAT,
		OP_WRITE,
		OP_DRAIN
	} op_kind_t;

	typedef struct packed {
		op_kind_t             kind;
		cfg_reg_t             idx;
		logic [CFG_DAT_W-1:0] data;
		logic [CYCLES_W-1:0]  cycles;
		logic                 steady;
	} op_t;

	typedef struct packed {
		logic [DIV_W-1:0]   div;
		logic [TIMA_W-1:0]  tima;
		logic               irq;
		logic [FRAME_W-1:0] frame;
		logic               steady;
	} tick_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CYCLES_W-1:0]  elapsed_cycles = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DIV_W-1:0]     divider_value;
	logic [TIMA_W-1:0]    timer_value;
	logic                 timer_interrupt;
	logic [FRAME_W-1:0]   frame_position;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	op_t          stim_q[$];
	tick_result_t pending_q[$];

	// predictor copy of registers and counters
	cfg_t   cfg_shadow;
	state_t tmr;

	int unsigned err_count = 0;
	int unsigned beats_queued = 0;
	int unsigned send_gap = 0;
	int unsigned rdy_stall = 0;
	int unsigned quiet_cycles = 0;
	logic        cur_steady = 1'b0;

	div_tima_timer_step_core #(
		.FRAME_LENGTH(FRAME_LEN)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.elapsed_cycles (elapsed_cycles),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.divider_value  (divider_value),
		.timer_value    (timer_value),
		.timer_interrupt(timer_interrupt),
		.frame_position (frame_position),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #4 clk = ~clk;

	// Advance the predicted counters by one beat and queue the result it must produce
	task automatic advance_timers(input logic [CYCLES_W-1:0] cyc, input logic steady);
		int unsigned  clocks;
		int unsigned  span;
		int unsigned  rate;
		int unsigned  ticks;
		tick_result_t r;
		clocks = cyc * (cfg_shadow.double_speed ? 2 : 4);
		span = tmr.div_res + clocks;
		tmr.div_count = DIV_W'(tmr.div_count + span / 256);
		tmr.div_res = DIV_W'(span % 256);
		r.irq = 1'b0;
		if (cfg_shadow.timer_enable) begin
			case (cfg_shadow.clock_select)
				SEL_16:  rate = 16;
				SEL_64:  rate = 64;
				SEL_256: rate = 256;
				default: rate = 1024;
			endcase
			span = tmr.tima_res + clocks;
			ticks = span / rate;
			if (tmr.reload_pending) begin
				// reload never raises the interrupt, even when the sum wraps
				tmr.tima_count = TIMA_W'(cfg_shadow.timer_modulo + ticks);
				tmr.reload_pending = 1'b0;
			end else if (tmr.tima_count + ticks > 8'hFF) begin
				r.irq = 1'b1;
				tmr.tima_count = '0;
				tmr.reload_pending = 1'b1;
			end else begin
				tmr.tima_count = TIMA_W'(tmr.tima_count + ticks);
			end
			tmr.tima_res = TRES_W'(span % rate);
		end
		tmr.frame_clock = FRAME_W'((tmr.frame_clock + clocks) % FRAME_LEN);
		r.div = tmr.div_count;
		r.tima = tmr.tima_count;
		r.frame = tmr.frame_clock;
		r.steady = steady;
		pending_q.push_back(r);
	endtask

	task automatic push_beat(input logic [CYCLES_W-1:0] cyc, input logic steady);
		op_t op;
		op = '0;
		op.kind = OP_BEAT;
		op.cycles = cyc;
		op.steady = steady;
		stim_q.push_back(op);
		beats_queued++;
	endtask

	task automatic push_write(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] data);
		op_t op;
		op = '0;
		op.kind = OP_WRITE;
		op.idx = idx;
		op.data = data;
		stim_q.push_back(op);
	endtask

	task automatic push_drain();
		op_t op;
		op = '0;
		op.kind = OP_DRAIN;
		stim_q.push_back(op);
	endtask

	// Driver: hold a beat until accepted, idle at random after non-steady beats, write registers only when drained
	always @(posedge clk) begin : drive
		logic nxt_valid;
		logic nxt_we;
		op_t  op;
		if (arst_n) begin
			nxt_valid = in_valid;
			nxt_we = 1'b0;
			if (in_valid && in_ready) begin
				advance_timers(elapsed_cycles, cur_steady);
				nxt_valid = 1'b0;
				send_gap = cur_steady ? 0 : $urandom_range(0, 5);
			end
			if (!nxt_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (stim_q.size() != 0) begin
					op = stim_q[0];
					case (op.kind)
						OP_BEAT: begin
							nxt_valid = 1'b1;
							elapsed_cycles <= op.cycles;
							cur_steady = op.steady;
							void'(stim_q.pop_front());
						end
						OP_WRITE: begin
							if (pending_q.size() == 0) begin
								nxt_we = 1'b1;
								cfg_index <= op.idx;
								cfg_data <= op.data;
								case (op.idx)
									REG_TIMER_ENABLE: cfg_shadow.timer_enable = op.data[0];
									REG_CLOCK_SELECT: cfg_shadow.clock_select = clk_sel_t'(op.data[1:0]);
									REG_TIMER_MODULO: cfg_shadow.timer_modulo = op.data;
									REG_DOUBLE_SPEED: cfg_shadow.double_speed = op.data[0];
									default: ;
								endcase
								void'(stim_q.pop_front());
							end
						end
						default: begin
							// pause the sender until every result is back
							if (pending_q.size() == 0)
								void'(stim_q.pop_front());
						end
					endcase
				end
			end
			in_valid <= nxt_valid;
			cfg_we <= nxt_we;
		end
	end

	// Monitor: check each result beat against the oldest prediction, stall ready at random after non-steady beats
	always @(posedge clk) begin : observe
		tick_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					if (err_count < SHOW_ERRS)
						$display("unexpected result beat: div=%0d tima=%0d irq=%0d frame=%0d",
							divider_value, timer_value, timer_interrupt, frame_position);
					err_count++;
				end else begin
					want = pending_q.pop_front();
					if (divider_value !== want.div || timer_value !== want.tima ||
						timer_interrupt !== want.irq || frame_position !== want.frame) begin
						if (err_count < SHOW_ERRS) begin
							$write("mismatch: exp div=%0d tima=%0d irq=%0d frame=%0d, ",
								want.div, want.tima, want.irq, want.frame);
							$display("got div=%0d tima=%0d irq=%0d frame=%0d",
								divider_value, timer_value, timer_interrupt, frame_position);
						end
						err_count++;
					end
					rdy_stall = want.steady ? 0 : $urandom_range(0, 5);
				end
			end
			if (rdy_stall != 0) begin
				out_ready <= 1'b0;
				rdy_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: the gap per beat is made of idling, stall and latency; fail the run when it goes quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int unsigned      phase_len;
		int unsigned      k;
		logic             steady;
		logic [CYCLES_W-1:0] cyc;
		cfg_shadow = '0;
		tmr = '0;

		// Disabled timer: divider and frame only, both speeds, field extremes
		push_beat(6'd0, 1'b0);
		push_beat(6'd63, 1'b0);
		push_write(REG_DOUBLE_SPEED, 8'd1);
		push_beat(6'd1, 1'b0);
		push_beat(6'd62, 1'b0);

		// Fast rate from zero until the counter overflows
		push_write(REG_DOUBLE_SPEED, 8'd0);
		push_write(REG_TIMER_MODULO, 8'hFF);
		push_write(REG_CLOCK_SELECT, CFG_DAT_W'(SEL_16));
		push_write(REG_TIMER_ENABLE, 8'd1);
		for (k = 0; k < 17; k++)
			push_beat(6'd63, 1'b1);

		// Disable with the reload armed; it must survive
		push_write(REG_TIMER_ENABLE, 8'd0);
		push_beat(6'd10, 1'b0);

		// Reload at the slowest rate, build residue, then switch to the fast rate
		push_write(REG_TIMER_ENABLE, 8'd1);
		push_write(REG_CLOCK_SELECT, CFG_DAT_W'(SEL_1024));
		push_beat(6'd63, 1'b0);
		push_beat(6'd63, 1'b0);
		push_write(REG_CLOCK_SELECT, CFG_DAT_W'(SEL_16));
		push_beat(6'd0, 1'b0);

		// Random phases, each opened by up to four register writes
		while (beats_queued < RAND_BEATS) begin
			phase_len = $urandom_range(10, 60);
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				push_write(REG_TIMER_ENABLE, CFG_DAT_W'($urandom_range(0, 3) != 0));
			if ($urandom_range(0, 1))
				push_write(REG_CLOCK_SELECT, CFG_DAT_W'($urandom_range(0, 3)));
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0:       push_write(REG_TIMER_MODULO, 8'h00);
					1:       push_write(REG_TIMER_MODULO, 8'hFF);
					default: push_write(REG_TIMER_MODULO, CFG_DAT_W'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 2) == 0)
				push_write(REG_DOUBLE_SPEED, CFG_DAT_W'($urandom_range(0, 1)));
			for (k = 0; k < phase_len; k++) begin
				case ($urandom_range(0, 7))
					0:       cyc = '0;
					1:       cyc = '1;
					default: cyc = CYCLES_W'($urandom_range(0, 63));
				endcase
				push_beat(cyc, steady);
				if ($urandom_range(0, 49) == 0)
					push_drain();
			end
		end

		// Hold reset, then release away from the active edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain all beats, then allow for the pipeline latency
		while (stim_q.size() != 0 || in_valid || pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
